>>> hdl/ffba_pkg.sv
package ffba_pkg;

    localparam int DEFAULT_NUM_BLOCKS  = 64;
    localparam int DEFAULT_BLOCK_BYTES = 64;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_bytes;
        logic [15:0] release_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] start_offset;
        logic [6:0]  run_blocks;
        logic [6:0]  free_blocks;
        logic [12:0] held_bytes;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
        logic [31:0] fail_total;
    } t_out_item;

endpackage

>>> hdl/ffba_map_ram.sv
module ffba_map_ram #(
    parameter int DEPTH = ffba_pkg::DEFAULT_NUM_BLOCKS,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);
    // One used bit per block, one write and one registered read per cycle.
    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ffba_div.sv
module ffba_div #(
    parameter int DIVISOR = ffba_pkg::DEFAULT_BLOCK_BYTES,
    parameter int WIDTH   = 16,
    localparam int RW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot,
    output logic [RW-1:0]    o_rem
);
    // Division by a constant through its reciprocal. With L = clog2(DIVISOR)
    // and M = ceil(2^(WIDTH+L) / DIVISOR), (x * M) >> (WIDTH+L) is the exact
    // quotient for every x below 2^WIDTH. The product is registered first,
    // then the quotient and remainder, and o_done rises together with them.
    localparam int     SH    = WIDTH + $clog2(DIVISOR);
    localparam int     MW    = WIDTH + 1;
    localparam int     PW    = WIDTH + MW;
    localparam longint RECIP =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [MW-1:0]    RECIP_C = MW'(RECIP);
    localparam logic [WIDTH-1:0] DIV_C   = WIDTH'(DIVISOR);

    logic             r_busy;
    logic             r_done;
    logic [PW-1:0]    r_prod;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_quot;
    logic [RW-1:0]    r_rem;

    logic [WIDTH-1:0] w_quot;
    logic [WIDTH-1:0] w_back;

    assign w_quot = WIDTH'(r_prod >> SH);
    assign w_back = w_quot * DIV_C;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
            if (i_start) begin
                r_prod <= PW'(i_dividend) * PW'(RECIP_C);
                r_dvd  <= i_dividend;
            end
            if (r_busy) begin
                r_quot <= w_quot;
                r_rem  <= RW'(r_dvd - w_back);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> hdl/first_fit_block_allocator.sv
// First-fit allocator over a pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes.
// The input channel (i_in_valid, o_in_ready, i_in_item) takes one item per
// request: allocate, free or clear. Each item yields exactly one result item
// on the output channel (o_out_valid, i_out_ready, o_out_item) with the
// status, the run touched, and all counters as they stand after the item.
// Items are handled one at a time. An allocate scans the blocks in order
// (at most NUM_BLOCKS of them), then marks each block of the run found.
// A free first turns the offset into a block index in the divider, then
// visits each block it releases, and the unused block that ends the run
// if there is one. A clear sweeps every block of the used-bit memory,
// and ignored requests go straight to their result. The single read and
// write port of the used-bit memory limits the pace: one block is visited
// per cycle. After reset the block sweeps every used bit to zero and holds
// o_in_ready low meanwhile. A result sits in an output
// register; the next item is accepted while it waits, and a finished item
// waits in its last state until the receiver has taken the previous one.
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = ffba_pkg::DEFAULT_NUM_BLOCKS,
    parameter int BLOCK_BYTES = ffba_pkg::DEFAULT_BLOCK_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffba_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffba_pkg::t_out_item o_out_item
);
    import ffba_pkg::*;

    localparam int AW   = $clog2(NUM_BLOCKS);
    localparam int CW   = $clog2(NUM_BLOCKS + 1);
    localparam int POOL = NUM_BLOCKS * BLOCK_BYTES;
    localparam int LBW  = $clog2(POOL + 1);
    localparam int RW   = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_DIV,
        S_FREE,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic            r_clr_reply;
    logic [AW-1:0]   r_ptr;
    logic [AW-1:0]   r_start;
    logic [LBW-1:0]  r_len_bytes;
    logic [CW-1:0]   r_mark_left;
    logic [CW-1:0]   r_run;
    logic [15:0]     r_req;
    logic [15:0]     r_rel;
    logic [CW-1:0]   r_used_cnt;
    logic [31:0]     r_alloc_cnt;
    logic [31:0]     r_free_cnt;
    logic [31:0]     r_fail_cnt;
    logic [1:0]      r_res_status;
    logic [11:0]     r_res_off;
    logic [6:0]      r_res_run;
    logic            r_out_valid;
    t_out_item       r_out_item;

    logic            w_in_accept;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic            w_wdata;
    logic            w_rdata;
    logic            w_div_start;
    logic            w_div_done;
    logic [15:0]     w_quot;
    logic [RW-1:0]   w_rem;
    logic [AW-1:0]   w_run_start;
    logic [LBW-1:0]  w_sum;
    logic            w_found;
    logic [CW-1:0]   w_need;
    logic [CW-1:0]   w_run_inc;
    logic            w_out_free;
    logic            w_out_load;
    logic            w_pool_hit;

    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_out_load  = (r_state == S_FINISH) && w_out_free;
    assign w_pool_hit  = (32'(i_in_item.release_offset) < 32'(POOL));

    // Scan arithmetic: the run in progress is tracked in bytes so that the
    // request never needs to be divided into blocks.
    assign w_run_start = (r_len_bytes == '0) ? r_ptr : r_start;
    assign w_sum       = r_len_bytes + LBW'(BLOCK_BYTES);
    assign w_found     = !w_rdata && (32'(w_sum) >= 32'(r_req));
    assign w_need      = CW'(r_ptr) - CW'(w_run_start) + CW'(1);
    assign w_run_inc   = r_run + CW'(1);

    // Memory port control.
    always_comb begin
        w_re        = 1'b0;
        w_raddr     = r_ptr + AW'(1);
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_INIT: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                if (w_in_accept && i_in_item.opcode == OP_ALLOC
                        && i_in_item.request_bytes != '0) begin
                    w_re    = 1'b1;
                    w_raddr = '0;
                end
                if (w_in_accept && i_in_item.opcode == OP_FREE && w_pool_hit) begin
                    w_div_start = 1'b1;
                end
            end
            S_SCAN: begin
                w_re = (r_ptr != LAST);
            end
            S_MARK: begin
                w_we    = 1'b1;
                w_wdata = 1'b1;
            end
            S_DIV: begin
                w_re    = w_div_done;
                w_raddr = AW'(w_quot);
            end
            S_FREE: begin
                w_we = w_rdata;
                w_re = w_rdata && (r_ptr != LAST);
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    ffba_map_ram #(
        .DEPTH (NUM_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffba_div #(
        .DIVISOR (BLOCK_BYTES),
        .WIDTH   (16)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_in_item.release_offset),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_reply <= 1'b0;
            r_ptr       <= '0;
            r_used_cnt  <= '0;
            r_alloc_cnt <= '0;
            r_free_cnt  <= '0;
            r_fail_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + AW'(1);
                    if (r_ptr == LAST) begin
                        r_state <= r_clr_reply ? S_FINISH : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_res_status <= ST_IGNORED;
                        r_res_off    <= '0;
                        r_res_run    <= '0;
                        r_state      <= S_FINISH;
                        unique case (i_in_item.opcode)
                            OP_ALLOC: begin
                                if (i_in_item.request_bytes != '0) begin
                                    r_req       <= i_in_item.request_bytes;
                                    r_ptr       <= '0;
                                    r_start     <= '0;
                                    r_len_bytes <= '0;
                                    r_state     <= S_SCAN;
                                end
                            end
                            OP_FREE: begin
                                if (w_pool_hit) begin
                                    r_rel   <= i_in_item.release_offset;
                                    r_state <= S_DIV;
                                end
                            end
                            OP_CLEAR: begin
                                r_res_status <= ST_DONE;
                                r_used_cnt   <= '0;
                                r_alloc_cnt  <= '0;
                                r_free_cnt   <= '0;
                                r_fail_cnt   <= '0;
                                r_ptr        <= '0;
                                r_clr_reply  <= 1'b1;
                                r_state      <= S_INIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_found) begin
                        r_ptr        <= w_run_start;
                        r_mark_left  <= w_need;
                        r_used_cnt   <= r_used_cnt + w_need;
                        r_alloc_cnt  <= r_alloc_cnt + 32'd1;
                        r_res_status <= ST_DONE;
                        r_res_off    <= 12'(32'(w_run_start) * 32'(BLOCK_BYTES));
                        r_res_run    <= 7'(w_need);
                        r_state      <= S_MARK;
                    end else if (r_ptr == LAST) begin
                        r_fail_cnt   <= r_fail_cnt + 32'd1;
                        r_res_status <= ST_FAIL;
                        r_state      <= S_FINISH;
                    end else begin
                        r_ptr       <= r_ptr + AW'(1);
                        r_start     <= w_run_start;
                        r_len_bytes <= w_rdata ? '0 : w_sum;
                    end
                end
                S_MARK: begin
                    r_ptr       <= r_ptr + AW'(1);
                    r_mark_left <= r_mark_left - CW'(1);
                    if (r_mark_left == CW'(1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_ptr        <= AW'(w_quot);
                        r_run        <= '0;
                        r_res_status <= ST_DONE;
                        r_res_off    <= 12'(r_rel - 16'(w_rem));
                        r_state      <= S_FREE;
                    end
                end
                S_FREE: begin
                    if (w_rdata && r_ptr != LAST) begin
                        r_ptr <= r_ptr + AW'(1);
                        r_run <= w_run_inc;
                    end else begin
                        r_free_cnt <= r_free_cnt + 32'd1;
                        r_state    <= S_FINISH;
                        if (w_rdata) begin
                            r_used_cnt <= r_used_cnt - w_run_inc;
                            r_res_run  <= 7'(w_run_inc);
                        end else begin
                            r_used_cnt <= r_used_cnt - r_run;
                            r_res_run  <= 7'(r_run);
                        end
                    end
                end
                S_FINISH: begin
                    r_clr_reply <= 1'b0;
                    if (w_out_free) begin
                        r_out_item.status       <= r_res_status;
                        r_out_item.start_offset <= r_res_off;
                        r_out_item.run_blocks   <= r_res_run;
                        r_out_item.free_blocks  <= 7'(CW'(NUM_BLOCKS) - r_used_cnt);
                        r_out_item.held_bytes   <=
                            13'(32'(r_used_cnt) * 32'(BLOCK_BYTES));
                        r_out_item.alloc_total  <= r_alloc_cnt;
                        r_out_item.free_total   <= r_free_cnt;
                        r_out_item.fail_total   <= r_fail_cnt;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The used-block count can never exceed the pool.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= CW'(NUM_BLOCKS))
        else $error("used block count exceeds pool size");

    // The single memory never writes and reads the same block in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("memory read and write hit the same block");

    // A clear drops every counter at once.
    a_clear_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_in_item.opcode == OP_CLEAR)
            |=> (r_used_cnt == '0 && r_alloc_cnt == '0 && r_fail_cnt == '0))
        else $error("clear did not reset the counters");

    // A marking pass always has at least one block left to write.
    a_mark_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_mark_left != '0))
        else $error("marking pass with nothing to mark");

    // A failed allocation reports no run.
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.status == ST_FAIL)
            |-> (r_out_item.run_blocks == '0 && r_out_item.start_offset == '0))
        else $error("failed allocation reports a run");

endmodule
